// ----- src/prsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsd_pkg
// types and constants shared by the rate and port scan detector
// ----------------------------------------------------------------------------
package prsd_pkg;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_RATE = 2'd1;
   localparam logic [1:0] KIND_SCAN = 2'd2;
   localparam logic [1:0] KIND_FULL = 2'd3;

   localparam logic       CMD_PACKET = 1'b0;
   localparam logic       CMD_CLEAR  = 1'b1;

   localparam logic [7:0] PROTO_TCP = 8'd6;

   localparam logic [1:0] REG_RATE_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_SCAN_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_WINDOW_SECONDS = 2'd2;

   localparam logic [15:0] RATE_THRESHOLD_RESET = 16'd10;
   localparam logic [4:0]  SCAN_THRESHOLD_RESET = 5'd10;
   localparam logic [16:0] WINDOW_SECONDS_RESET = 17'd60;

   typedef struct packed {
      logic        command;
      logic [31:0] src_ip;
      logic [31:0] dest_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  protocol;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic [1:0]  alert_kind;
      logic [31:0] alert_source_ip;
      logic [31:0] alert_dest_ip;
      logic [15:0] alert_source_port;
      logic [15:0] alert_dest_port;
      logic [7:0]  alert_protocol;
      logic [31:0] alert_time;
   } rsp_type;

   typedef struct packed {
      logic [15:0] rate_threshold;
      logic [4:0]  scan_threshold;
      logic [16:0] window_seconds;
   } cfg_type;

endpackage

// ----- src/prsd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsd_queue
// short item queue between the front end and the table engine
// ----------------------------------------------------------------------------
module prsd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  prsd_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_take,
   output prsd_pkg::req_type out_data
);
   import prsd_pkg::*;

   req_type    slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic       push, pop;

   assign in_stall  = (count_ff == 2'd2);
   assign push      = in_valid && !in_stall;
   assign out_valid = (count_ff != 2'd0);
   assign pop       = out_valid && out_take;
   assign out_data  = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end
endmodule

// ----- src/prsd_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsd_engine
// table lookup, rate check and port set check, one item at a time
// ----------------------------------------------------------------------------
module prsd_engine #(
   parameter int TABLE_ENTRIES = 64,
   parameter int PORT_SLOTS    = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  prsd_pkg::cfg_type cfg,
   input  logic              item_valid,
   output logic              item_take,
   input  prsd_pkg::req_type item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output prsd_pkg::rsp_type rsp_data
);
   import prsd_pkg::*;

   localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int PW = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
   localparam int CW = $clog2(PORT_SLOTS + 1);
   localparam int SW = EW + PW;
   localparam logic [EW:0] LAST_E = (EW+1)'(TABLE_ENTRIES - 1);
   localparam logic [CW-1:0] SLOTS_C = CW'(PORT_SLOTS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SRCH  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_RATE  = 3'd3;
   localparam logic [2:0] ST_PORTS = 3'd4;
   localparam logic [2:0] ST_SCAN  = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   // per entry flags in flip-flops, payload fields in memories
   logic [TABLE_ENTRIES-1:0] used_ff, wsv_ff, ract_ff, sact_ff;
   logic [31:0] addr_mem  [TABLE_ENTRIES];
   logic [15:0] wcnt_mem  [TABLE_ENTRIES];
   logic [31:0] wst_mem   [TABLE_ENTRIES];
   logic [31:0] rat_mem   [TABLE_ENTRIES];
   logic [31:0] sat_mem   [TABLE_ENTRIES];
   logic [CW-1:0] pcnt_mem [TABLE_ENTRIES];
   logic [15:0] port_mem  [2**SW];

   logic [2:0]    state_ff;
   req_type       cur_ff;
   logic [EW:0]   idx_ff;
   logic          found_ff, free_ok_ff;
   logic [EW-1:0] hit_ff, free_ff, ent_ff;
   logic [31:0]   addr_rd_ff;
   logic [15:0]   wcnt_ff;
   logic [31:0]   wst_ff, rat_ff, sat_ff;
   logic [CW-1:0] pcnt_ff, pn_ff;
   logic [PW:0]   pidx_ff;
   logic [15:0]   port_rd_ff;
   logic          port_rd_vld_ff, pfound_ff, sact_cur_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;
   logic          new_ent_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign item_take = (state_ff == ST_IDLE) && item_valid && !rsp_valid_ff;

   function automatic logic expired(input logic [31:0] now, input logic [31:0] then_t,
                                    input logic [16:0] win);
      logic [31:0] d;
      d = now - then_t;
      return d > {15'd0, win};
   endfunction

   // rate decision, entry fields for the chosen entry
   logic          ract_e, wsv_e, rate_hit;
   logic [15:0]   wcnt_a, wcnt_b, wcnt_new;
   logic [31:0]   wst_new;
   logic          ract_new, wsv_new;
   always_comb begin
      ract_e  = ract_ff[ent_ff] && !new_ent_ff;
      wsv_e   = wsv_ff[ent_ff] && !new_ent_ff;
      wcnt_a  = new_ent_ff ? 16'd0 : wcnt_ff;
      wst_new = wst_ff;
      wsv_new = wsv_e;
      ract_new = ract_e;
      if (ract_e && expired(cur_ff.now_seconds, rat_ff, cfg.window_seconds)) begin
         wcnt_a = 16'd0; wst_new = cur_ff.now_seconds; wsv_new = 1'b1; ract_new = 1'b0;
      end
      if (!ract_new) begin
         if (!wsv_new || expired(cur_ff.now_seconds, wst_new, cfg.window_seconds)) begin
            wcnt_a = 16'd0; wst_new = cur_ff.now_seconds; wsv_new = 1'b1;
         end
      end
      wcnt_b   = (wcnt_a != 16'hFFFF) ? wcnt_a + 16'd1 : wcnt_a;
      rate_hit = (wcnt_b > cfg.rate_threshold) && !ract_new;
      wcnt_new = rate_hit ? 16'd0 : wcnt_b;
   end

   // scan cooldown state for the chosen entry
   logic sact_e, scan_exp;
   assign sact_e   = sact_ff[ent_ff] && !new_ent_ff;
   assign scan_exp = sact_e && expired(cur_ff.now_seconds, sat_ff, cfg.window_seconds);

   logic [SW-1:0] paddr_rd, paddr_wr;
   assign paddr_rd = {ent_ff, pidx_ff[PW-1:0]};
   assign paddr_wr = {ent_ff, pn_ff[PW-1:0]};

   logic [CW-1:0] pcnt_after;
   assign pcnt_after = (!pfound_ff && pn_ff < SLOTS_C) ? pn_ff + CW'(1) : pn_ff;

   logic scan_hit;
   assign scan_hit = (32'(pcnt_after) > 32'(cfg.scan_threshold)) && !sact_cur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         wsv_ff       <= '0;
         ract_ff      <= '0;
         sact_ff      <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (item_take) begin
                  cur_ff     <= item;
                  idx_ff     <= '0;
                  found_ff   <= 1'b0;
                  free_ok_ff <= 1'b0;
                  if (item.command == CMD_CLEAR) begin
                     used_ff <= '0;
                     rsp_ff  <= '0;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_SRCH;
                  end
               end
            end
            // one entry a cycle, address read registered
            ST_SRCH: begin
               addr_rd_ff <= addr_mem[idx_ff[EW-1:0]];
               if (idx_ff != '0) begin
                  if (used_ff[EW'(idx_ff - 1'b1)]) begin
                     if (addr_rd_ff == cur_ff.src_ip && !found_ff) begin
                        found_ff <= 1'b1; hit_ff <= EW'(idx_ff - 1'b1);
                     end
                  end else if (!free_ok_ff) begin
                     free_ok_ff <= 1'b1; free_ff <= EW'(idx_ff - 1'b1);
                  end
               end
               if (idx_ff == LAST_E + 1'b1) begin
                  state_ff <= ST_READ;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_READ: begin
               if (found_ff || free_ok_ff) begin
                  ent_ff     <= found_ff ? hit_ff : free_ff;
                  new_ent_ff <= !found_ff;
                  state_ff   <= ST_RATE;
               end else begin
                  rsp_ff <= '{KIND_FULL, cur_ff.src_ip, cur_ff.dest_ip, 16'd0, 16'd0,
                              cur_ff.protocol, cur_ff.now_seconds};
                  state_ff <= ST_OUT;
               end
            end
            ST_RATE: begin
               // registered reads were issued below on entry to this state
               if (new_ent_ff) begin
                  used_ff[ent_ff] <= 1'b1;
                  addr_mem[ent_ff] <= cur_ff.src_ip;
               end
               wcnt_mem[ent_ff] <= wcnt_new;
               wst_mem[ent_ff]  <= wst_new;
               wsv_ff[ent_ff]   <= wsv_new;
               ract_ff[ent_ff]  <= ract_new || rate_hit;
               if (rate_hit) rat_mem[ent_ff] <= cur_ff.now_seconds;
               if (new_ent_ff) sact_ff[ent_ff] <= 1'b0;
               // an expired scan cooldown restarts the port set
               sact_cur_ff <= sact_e && !scan_exp;
               pn_ff       <= (new_ent_ff || scan_exp) ? '0 : pcnt_ff;
               if (rate_hit) begin
                  if (new_ent_ff) pcnt_mem[ent_ff] <= '0;
                  rsp_ff <= '{KIND_RATE, cur_ff.src_ip, cur_ff.dest_ip, 16'd0, 16'd0,
                              cur_ff.protocol, cur_ff.now_seconds};
                  state_ff <= ST_OUT;
               end else if (cur_ff.protocol == PROTO_TCP) begin
                  pidx_ff        <= '0;
                  pfound_ff      <= 1'b0;
                  port_rd_vld_ff <= 1'b0;
                  state_ff       <= ST_PORTS;
               end else begin
                  if (new_ent_ff) pcnt_mem[ent_ff] <= '0;
                  rsp_ff   <= '0;
                  state_ff <= ST_OUT;
               end
            end
            // walk the stored ports, one read a cycle
            ST_PORTS: begin
               port_rd_ff     <= port_mem[paddr_rd];
               port_rd_vld_ff <= (CW'(pidx_ff) < pn_ff) &&
                                 (pidx_ff < (PW+1)'(PORT_SLOTS));
               if (port_rd_vld_ff && port_rd_ff == cur_ff.dst_port) pfound_ff <= 1'b1;
               if (pidx_ff == (PW+1)'(PORT_SLOTS)) begin
                  state_ff <= ST_SCAN;
               end else begin
                  pidx_ff <= pidx_ff + 1'b1;
               end
            end
            ST_SCAN: begin
               if (!pfound_ff && pn_ff < SLOTS_C) port_mem[paddr_wr] <= cur_ff.dst_port;
               sact_ff[ent_ff] <= sact_cur_ff || scan_hit;
               if (scan_hit) begin
                  sat_mem[ent_ff]  <= cur_ff.now_seconds;
                  pcnt_mem[ent_ff] <= '0;
                  rsp_ff <= '{KIND_SCAN, cur_ff.src_ip, cur_ff.dest_ip,
                              cur_ff.src_port, cur_ff.dst_port,
                              cur_ff.protocol, cur_ff.now_seconds};
               end else begin
                  pcnt_mem[ent_ff] <= pcnt_after;
                  rsp_ff <= '0;
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // registered field reads for the chosen entry
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         wcnt_ff <= wcnt_mem[found_ff ? hit_ff : free_ff];
         wst_ff  <= wst_mem[found_ff ? hit_ff : free_ff];
         rat_ff  <= rat_mem[found_ff ? hit_ff : free_ff];
         sat_ff  <= sat_mem[found_ff ? hit_ff : free_ff];
         pcnt_ff <= pcnt_mem[found_ff ? hit_ff : free_ff];
      end
   end
endmodule

// ----- src/packet_rate_and_port_scan_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_rate_and_port_scan_detector
// per source address rate and port scan alerts over a header stream
// ----------------------------------------------------------------------------
// req_ carries one header or a clear command per item (valid and stall);
// rsp_ returns exactly one result item per request, in order.
// a two entry queue parts the front end from the table engine, so items are
// taken while the engine works or its result waits on rsp_stall.
// a clear command empties the table; a packet runs the entry search, plus
// the port set walk on tcp, the searches running one stored entry a cycle
// over the memories.
// the engine works on one item at a time, its result out before the next.
// the engine holds its result while rsp_stall is high and starts no new item.
// csr_ is an apb style port: rate_threshold at 0, scan_threshold at 4,
// window_seconds at 8; reads return the values, pready is always high.
// reset sets the registers to 10, 10, 60 and empties the table at once.
// ----------------------------------------------------------------------------
module packet_rate_and_port_scan_detector #(
   parameter int TABLE_ENTRIES = 64,
   parameter int PORT_SLOTS    = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  prsd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output prsd_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import prsd_pkg::*;

   cfg_type cfg_ff;
   req_type q_data;
   logic    q_valid, q_take;
   logic [1:0] reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[3:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{RATE_THRESHOLD_RESET, SCAN_THRESHOLD_RESET, WINDOW_SECONDS_RESET};
      end else if (psel && penable && pwrite) begin
         unique case (reg_sel)
            REG_RATE_THRESHOLD: cfg_ff.rate_threshold <= pwdata[15:0];
            REG_SCAN_THRESHOLD: cfg_ff.scan_threshold <= pwdata[4:0];
            REG_WINDOW_SECONDS: cfg_ff.window_seconds <= pwdata[16:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (reg_sel)
         REG_RATE_THRESHOLD: prdata = {16'd0, cfg_ff.rate_threshold};
         REG_SCAN_THRESHOLD: prdata = {27'd0, cfg_ff.scan_threshold};
         REG_WINDOW_SECONDS: prdata = {15'd0, cfg_ff.window_seconds};
         default:            prdata = 32'd0;
      endcase
   end

   prsd_queue u_queue (
      .clock, .reset,
      .in_valid (req_valid), .in_stall (req_stall), .in_data (req_data),
      .out_valid (q_valid), .out_take (q_take), .out_data (q_data)
   );

   prsd_engine #(.TABLE_ENTRIES(TABLE_ENTRIES), .PORT_SLOTS(PORT_SLOTS)) u_engine (
      .clock, .reset, .cfg (cfg_ff),
      .item_valid (q_valid), .item_take (q_take), .item (q_data),
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
